// ----- rtl/c39cv_pkg.sv -----
// shared types, character codes and table values for the code 39 check validator
`default_nettype none

package c39cv_pkg;

  localparam int unsigned SYM_W = 8;
  localparam int unsigned VAL_W = 6;

  localparam logic [VAL_W:0] MOD_BASE = 7'd43;

  // character codes: digit and letter range bounds, then the characters outside those ranges
  localparam logic [SYM_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE   = 8'h39;
  localparam logic [SYM_W-1:0] CH_A      = 8'h41;
  localparam logic [SYM_W-1:0] CH_Z      = 8'h5A;
  localparam logic [SYM_W-1:0] CH_DASH   = 8'h2D;
  localparam logic [SYM_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [SYM_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [SYM_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_PCT    = 8'h25;

  localparam logic [VAL_W-1:0] VAL_LETTER_BASE = 6'd10;
  localparam logic [VAL_W-1:0] VAL_DASH        = 6'd36;
  localparam logic [VAL_W-1:0] VAL_DOT         = 6'd37;
  localparam logic [VAL_W-1:0] VAL_UNDER       = 6'd38;
  localparam logic [VAL_W-1:0] VAL_DOLLAR      = 6'd39;
  localparam logic [VAL_W-1:0] VAL_SLASH       = 6'd40;
  localparam logic [VAL_W-1:0] VAL_PLUS        = 6'd41;
  localparam logic [VAL_W-1:0] VAL_PCT         = 6'd42;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_NO_DATA  = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
  } decode_t;

endpackage

`default_nettype wire

// ----- rtl/c39cv_if.sv -----
// valid/ready channel interfaces for characters in and check results out
`default_nettype none

interface c39cv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface c39cv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] expected_check;
  logic [5:0] received_check;

  modport source (output valid, output status, output expected_check,
                  output received_check, input ready);
  modport sink   (input valid, input status, input expected_check,
                  input received_check, output ready);
endinterface

`default_nettype wire

// ----- rtl/c39cv_in_stage.sv -----
// input register stage holding one accepted character
`default_nettype none

module c39cv_in_stage
  import c39cv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_last,
  input  logic             advance,
  output logic             item_valid,
  output item_t            item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.symbol <= in_symbol;
      item_r.last   <= in_last;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ----- rtl/c39cv_decode.sv -----
// maps a character code to its table value 0..42, or flags it as not in the table
`default_nettype none

module c39cv_decode
  import c39cv_pkg::*;
(
  input  logic [SYM_W-1:0] symbol,
  output decode_t          dec
);

  always_comb begin
    dec = '0;
    if (symbol >= CH_ZERO && symbol <= CH_NINE) begin
      dec.valid = 1'b1;
      dec.value = VAL_W'(symbol - CH_ZERO);
    end else if (symbol >= CH_A && symbol <= CH_Z) begin
      dec.valid = 1'b1;
      dec.value = VAL_W'(symbol - CH_A) + VAL_LETTER_BASE;
    end else begin
      case (symbol)
        CH_DASH: begin
          dec.valid = 1'b1;
          dec.value = VAL_DASH;
        end
        CH_DOT: begin
          dec.valid = 1'b1;
          dec.value = VAL_DOT;
        end
        CH_UNDER: begin
          dec.valid = 1'b1;
          dec.value = VAL_UNDER;
        end
        CH_DOLLAR: begin
          dec.valid = 1'b1;
          dec.value = VAL_DOLLAR;
        end
        CH_SLASH: begin
          dec.valid = 1'b1;
          dec.value = VAL_SLASH;
        end
        CH_PLUS: begin
          dec.valid = 1'b1;
          dec.value = VAL_PLUS;
        end
        CH_PCT: begin
          dec.valid = 1'b1;
          dec.value = VAL_PCT;
        end
        default: begin
          dec = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/c39cv_accum.sv -----
// modulo-43 running sum, symbol flags and the registered check result
`default_nettype none

module c39cv_accum
  import c39cv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  logic             item_last,
  input  decode_t          dec,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [VAL_W-1:0] out_expected,
  output logic [VAL_W-1:0] out_received
);

  logic [VAL_W-1:0] sum_r, sum_nxt;
  logic             seen_r, seen_nxt;
  logic             bad_r, bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic [VAL_W-1:0] expected_r;
  logic [VAL_W-1:0] received_r, received_nxt;
  logic [VAL_W:0]   sum_wide;
  logic             emit;

  // a data character never waits on the result side
  assign advance = item_valid && (!item_last || !out_valid_r || out_ready);
  assign emit    = advance && item_last;

  always_comb begin
    sum_wide = {1'b0, sum_r} + {1'b0, dec.value};
    if (sum_wide >= MOD_BASE) begin
      sum_wide = sum_wide - MOD_BASE;
    end
  end

  always_comb begin
    received_nxt = dec.valid ? dec.value : '0;
    if (bad_r || !dec.valid) begin
      status_nxt = ST_BAD_CHAR;
    end else if (!seen_r) begin
      status_nxt = ST_NO_DATA;
    end else if (received_nxt != sum_r) begin
      status_nxt = ST_MISMATCH;
    end else begin
      status_nxt = ST_VALID;
    end
  end

  always_comb begin
    sum_nxt  = sum_r;
    seen_nxt = seen_r;
    bad_nxt  = bad_r;
    if (advance) begin
      if (item_last) begin
        sum_nxt  = '0;
        seen_nxt = 1'b0;
        bad_nxt  = 1'b0;
      end else if (dec.valid) begin
        sum_nxt  = sum_wide[VAL_W-1:0];
        seen_nxt = 1'b1;
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      seen_r      <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      seen_r      <= seen_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_r   <= status_nxt;
      expected_r <= sum_r;
      received_r <= received_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_expected = expected_r;
  assign out_received = received_r;

endmodule

`default_nettype wire

// ----- rtl/code39_check_validator_unit.sv -----
// top level of the code 39 modulo-43 check character validator
//
//   channel   dir  payload                                   transaction
//   in_chan   in   symbol[7:0], last                         one character
//   out_chan  out  status[1:0], expected_check[5:0],         one result per last
//                  received_check[5:0]
//
// one character per cycle unless a last character waits on the result register;
// a result is offered once its last character has passed the input register
// and then the result register; data characters always drain, a last character
// waits only while the result register is full and out_chan.ready is low
// rst_n clears the running sum, both flags and both valid registers
`default_nettype none

module code39_check_validator_unit
  import c39cv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  c39cv_in_if.sink     in_chan,
  c39cv_out_if.source  out_chan
);

  logic    advance;
  logic    item_valid;
  item_t   item;
  decode_t dec;

  c39cv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_symbol  (in_chan.symbol),
    .in_last    (in_chan.last),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  c39cv_decode u_decode (
    .symbol (item.symbol),
    .dec    (dec)
  );

  c39cv_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_last    (item.last),
    .dec          (dec),
    .advance      (advance),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_status   (out_chan.status),
    .out_expected (out_chan.expected_check),
    .out_received (out_chan.received_check)
  );

endmodule

`default_nettype wire

// ----- rtl/c39cv_checker.sv -----
// port-level checks for the code 39 check validator, bound to the top level
`default_nettype none

module c39cv_checker
  import c39cv_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [5:0] out_expected,
  input logic [5:0] out_received
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_expected) && $stable(out_received))
    else $error("result changed while stalled");

  a_valid_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_VALID |-> out_expected == out_received)
    else $error("valid status with differing check values");

  a_mismatch_differs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_MISMATCH |-> out_expected != out_received)
    else $error("mismatch status with equal check values");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_expected <= 6'd42 && out_received <= 6'd42)
    else $error("check value out of modulo-43 range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind code39_check_validator_unit c39cv_checker u_c39cv_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_status   (out_chan.status),
  .out_expected (out_chan.expected_check),
  .out_received (out_chan.received_check)
);

`default_nettype wire
